### rtl/fdli_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the feedback delay line: field widths, register
// indexes, reset values and the soft-clip lookup table. No dependencies.
package fdli_pkg;

    // Default store depth in samples.
    localparam int unsigned FDLI_DEPTH = 65536;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int MOD_W      = 21;
    localparam int DELAY_W    = 32;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TARGET  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 8'd3;

    // Configuration reset values.
    localparam logic [DELAY_W-1:0] DELAY_TARGET_RST  = 32'd0;
    localparam logic [COEF_W-1:0]  SMOOTHING_RST     = 16'd1024;
    localparam logic [COEF_W-1:0]  FEEDBACK_GAIN_RST = 16'd0;
    localparam logic [COEF_W-1:0]  WET_MIX_RST       = 16'd16384;

    // Soft-clip breakpoints: 32767 * tanh(k / 8) for k = 0..32.
    function automatic logic [15:0] clip_lut(input logic [5:0] k);
        logic [15:0] r;
        case (k)
            6'd0:  r = 16'd0;
            6'd1:  r = 16'd4075;
            6'd2:  r = 16'd8025;
            6'd3:  r = 16'd11742;
            6'd4:  r = 16'd15142;
            6'd5:  r = 16'd18173;
            6'd6:  r = 16'd20812;
            6'd7:  r = 16'd23065;
            6'd8:  r = 16'd24955;
            6'd9:  r = 16'd26518;
            6'd10: r = 16'd27796;
            6'd11: r = 16'd28829;
            6'd12: r = 16'd29659;
            6'd13: r = 16'd30321;
            6'd14: r = 16'd30846;
            6'd15: r = 16'd31261;
            6'd16: r = 16'd31588;
            6'd17: r = 16'd31845;
            6'd18: r = 16'd32047;
            6'd19: r = 16'd32205;
            6'd20: r = 16'd32328;
            6'd21: r = 16'd32425;
            6'd22: r = 16'd32500;
            6'd23: r = 16'd32559;
            6'd24: r = 16'd32605;
            6'd25: r = 16'd32641;
            6'd26: r = 16'd32669;
            6'd27: r = 16'd32690;
            6'd28: r = 16'd32707;
            6'd29: r = 16'd32720;
            6'd30: r = 16'd32731;
            6'd31: r = 16'd32739;
            6'd32: r = 16'd32745;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/feedback_delay_line_interp.sv
`timescale 1ns / 1ps
// Feedback delay line with smoothed, linearly interpolated read tap.
// Depends on fdli_pkg for widths and the clip table, and on fdli_ram.
// Input beat: i_sample_in, i_modulation and i_end_of_block, taken when
// i_in_valid is high and o_in_stall is low. Output beat: o_sample_out and
// o_end_of_block_out, delivered when o_out_valid is high and i_out_stall is
// low. Configuration writes use i_cfg_valid / o_cfg_ready (always ready),
// i_cfg_index and i_cfg_data; unknown indexes are ignored.
// Each beat runs through an eight-step sequencer: one step that forms both
// products, the delay update, two store reads on the single read port, the
// write-back, the tap sum, the mix and the output load. A result is
// registered in the output load step, and a new beat is taken in the
// cycle the result is loaded, so the block takes no new beat until
// the last one has run through every step.
// The output register holds a finished result while the receiver stalls;
// the next beat is taken as soon as that register can accept a new result.
// A synchronous reset loads the register defaults, zeroes the delay state
// and empties the store. The store needs no clearing pass: entries not yet
// written since reset (tracked by the write position and a wrap flag) read
// as zero.
module feedback_delay_line_interp
    import fdli_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = FDLI_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic signed [MOD_W-1:0]    i_modulation,
    input  logic                       i_end_of_block,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_end_of_block_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = ((AW + 16 > DELAY_W) ? AW + 16 : DELAY_W) + 1;
    localparam longint CAP_FULL = longint'(BUFFER_DEPTH - 1) * longint'(65536);
    localparam logic [DELAY_W-1:0] DELAY_CAP =
        (CAP_FULL > 64'h0000_0000_FFFF_FFFF) ? {DELAY_W{1'b1}} : DELAY_W'(CAP_FULL);
    localparam logic [PW-1:0] SPAN = PW'(longint'(BUFFER_DEPTH) * longint'(65536));
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL  = 9'b000000010,
        ST_DLY  = 9'b000000100,
        ST_RDB  = 9'b000001000,
        ST_RDA  = 9'b000010000,
        ST_TAP  = 9'b000100000,
        ST_SUM  = 9'b001000000,
        ST_MIX  = 9'b010000000,
        ST_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [DELAY_W-1:0] r_delay_target;
    logic [COEF_W-1:0]  r_smoothing;
    logic [COEF_W-1:0]  r_feedback_gain;
    logic [COEF_W-1:0]  r_wet_mix;

    // Architectural state.
    logic [AW-1:0]              r_wp;
    logic                       r_wrap;
    logic [DELAY_W-1:0]         r_sd;
    logic signed [SAMPLE_W-1:0] r_fb;

    // Working registers of the current beat.
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [MOD_W-1:0]    r_mod;
    logic                       r_eob;
    logic signed [49:0]         r_prod;
    logic signed [32:0]         r_fbp;
    logic [4:0]                 r_cidx;
    logic [11:0]                r_cfrac;
    logic                       r_cneg;
    logic [15:0]                r_cbase;
    logic signed [29:0]         r_cmul;
    logic signed [SAMPLE_W-1:0] r_clipv;
    logic [AW-1:0]              r_ia;
    logic [15:0]                r_f;
    logic                       r_va;
    logic                       r_vb;
    logic signed [SAMPLE_W-1:0] r_b;
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [33:0]         r_tmul;
    logic signed [33:0]         r_mx;
    logic signed [32:0]         r_mt;

    // Output register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_eob;

    logic accept_in;
    logic out_free;

    // Handshake.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) || ((r_state == ST_DONE) && out_free));
    assign accept_in  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid        = r_out_valid;
    assign o_sample_out       = r_out_sample;
    assign o_end_of_block_out = r_out_eob;

    // Multiply step: smoothing error and feedback gain.
    logic signed [32:0] smooth_diff;
    logic signed [49:0] smooth_prod;
    logic signed [32:0] fb_prod;

    assign smooth_diff = $signed({1'b0, r_sd}) - $signed({1'b0, r_delay_target});
    assign smooth_prod = smooth_diff * $signed({1'b0, r_smoothing});
    assign fb_prod     = r_fb * $signed({1'b0, r_feedback_gain});

    // Delay update with saturation, and soft-clip argument.
    logic signed [34:0] smooth_step;
    logic signed [36:0] d_sum;
    logic [DELAY_W-1:0] d_sat;
    logic signed [17:0] fb_add;
    logic signed [18:0] v_sum;
    logic [18:0]        v_abs;
    logic [16:0]        v_mag;

    assign smooth_step = $signed(r_prod[49:15]);
    assign d_sum = 37'($signed({1'b0, r_sd})) + 37'(r_mod) - 37'(smooth_step);

    always_comb begin
        if (d_sum[36]) begin
            d_sat = '0;
        end else if (d_sum > $signed({5'b0, DELAY_CAP})) begin
            d_sat = DELAY_CAP;
        end else begin
            d_sat = d_sum[DELAY_W-1:0];
        end
    end

    assign fb_add = $signed(r_fbp[32:15]);
    assign v_sum  = 19'(r_x) + 19'(fb_add);
    assign v_abs  = v_sum[18] ? 19'(-v_sum) : 19'(v_sum);
    assign v_mag  = (v_abs > 19'd131071) ? 17'h1FFFF : v_abs[16:0];

    // Read position behind the write position, wrapped into the store.
    logic [PW-1:0] pos_diff;
    logic [PW-1:0] pos;
    logic [AW-1:0] rd_ib;
    logic [AW-1:0] rd_ia;

    assign pos_diff = PW'({r_wp, 16'b0}) - PW'(r_sd);
    assign pos      = pos_diff[PW-1] ? (pos_diff + SPAN) : pos_diff;
    assign rd_ib    = pos[AW+15:16];
    assign rd_ia    = (rd_ib == '0) ? LAST_ADDR : (rd_ib - AW'(1));

    // Soft-clip table interpolation.
    logic [15:0]        clip_t0;
    logic [15:0]        clip_t1;
    logic signed [16:0] clip_diff;
    logic signed [17:0] clip_sum;

    assign clip_t0   = clip_lut({1'b0, r_cidx});
    assign clip_t1   = clip_lut({1'b0, r_cidx} + 6'd1);
    assign clip_diff = $signed({1'b0, clip_t1}) - $signed({1'b0, clip_t0});
    assign clip_sum  = $signed({2'b0, r_cbase}) + $signed(r_cmul[29:12]);

    // Store: one read port shared by both taps, written after both reads.
    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic signed [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0]        ram_rdata_raw;

    assign ram_we    = (r_state == ST_TAP);
    assign ram_raddr = (r_state == ST_RDB) ? rd_ib : r_ia;
    assign ram_rdata = $signed(ram_rdata_raw);

    fdli_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_clipv),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    // Tap interpolation and wet/dry mix.
    logic signed [SAMPLE_W-1:0] a_val;
    logic signed [16:0]         tap_diff;
    logic signed [17:0]         tap_sum;
    logic signed [17:0]         dry_w;
    logic signed [34:0]         mix_sum;
    logic signed [19:0]         mix_q;
    logic signed [SAMPLE_W-1:0] mix_sat;

    assign a_val    = r_va ? ram_rdata : '0;
    assign tap_diff = 17'(r_b) - 17'(a_val);
    assign tap_sum  = 18'(r_a) + $signed(r_tmul[33:16]);
    assign dry_w    = 18'sd32768 - $signed({2'b0, r_wet_mix});
    assign mix_sum  = 35'(r_mx) + 35'(r_mt);
    assign mix_q    = $signed(mix_sum[34:15]);

    always_comb begin
        if (mix_q > 20'sd32767) begin
            mix_sat = 16'sh7FFF;
        end else if (mix_q < -20'sd32768) begin
            mix_sat = 16'sh8000;
        end else begin
            mix_sat = 16'(mix_q);
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_DLY;
            ST_DLY:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_RDA;
            ST_RDA:  n_state = ST_TAP;
            ST_TAP:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_MIX;
            ST_MIX:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = accept_in ? ST_MUL : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_delay_target  <= DELAY_TARGET_RST;
            r_smoothing     <= SMOOTHING_RST;
            r_feedback_gain <= FEEDBACK_GAIN_RST;
            r_wet_mix       <= WET_MIX_RST;
            r_wp            <= '0;
            r_wrap          <= 1'b0;
            r_sd            <= '0;
            r_fb            <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELAY_TARGET:  r_delay_target  <= i_cfg_data;
                    CFG_SMOOTHING:     r_smoothing     <= i_cfg_data[COEF_W-1:0];
                    CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[COEF_W-1:0];
                    CFG_WET_MIX:       r_wet_mix       <= i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_DLY) begin
                r_sd <= d_sat;
            end

            // Advance the write position once the sample is stored.
            if (r_state == ST_TAP) begin
                if (r_wp == LAST_ADDR) begin
                    r_wp   <= '0;
                    r_wrap <= 1'b1;
                end else begin
                    r_wp <= r_wp + AW'(1);
                end
            end

            if (r_state == ST_SUM) begin
                r_fb <= 16'(tap_sum);
            end

            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_x   <= i_sample_in;
            r_mod <= i_modulation;
            r_eob <= i_end_of_block;
        end

        if (r_state == ST_MUL) begin
            r_prod <= smooth_prod;
            r_fbp  <= fb_prod;
        end

        if (r_state == ST_DLY) begin
            r_cidx  <= v_mag[16:12];
            r_cfrac <= v_mag[11:0];
            r_cneg  <= v_sum[18];
        end

        // First read issued; entries not written since reset read as zero.
        if (r_state == ST_RDB) begin
            r_ia    <= rd_ia;
            r_f     <= pos[15:0];
            r_vb    <= r_wrap || (rd_ib < r_wp);
            r_va    <= r_wrap || (rd_ia < r_wp);
            r_cmul  <= clip_diff * $signed({1'b0, r_cfrac});
            r_cbase <= clip_t0;
        end

        if (r_state == ST_RDA) begin
            r_b     <= r_vb ? ram_rdata : '0;
            r_clipv <= r_cneg ? 16'(-clip_sum) : 16'(clip_sum);
        end

        if (r_state == ST_TAP) begin
            r_a    <= a_val;
            r_tmul <= tap_diff * $signed({1'b0, r_f});
        end

        if (r_state == ST_MIX) begin
            r_mx <= r_x * dry_w;
            r_mt <= r_fb * $signed({1'b0, r_wet_mix});
        end

        if ((r_state == ST_DONE) && out_free) begin
            r_out_sample <= mix_sat;
            r_out_eob    <= r_eob;
        end
    end

endmodule

### rtl/fdli_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module fdli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
